>>> hdl/s256_pkg.sv
// Package for the SHA-256 byte stream hasher: types, codes, constants and round helpers.
package s256_pkg;

  typedef logic [7:0][31:0] work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RND,
    ST_ADD,
    ST_OUT
  } st_e;

  localparam logic [1:0] ACT_ABSORB  = 2'd0;
  localparam logic [1:0] ACT_ABS_FIN = 2'd1;
  localparam logic [1:0] ACT_FIN     = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_MAX = 6'd63;
  localparam logic [5:0] RND_LAST = 6'd63;
  localparam logic [2:0] LEN_LAST = 3'd7;
  localparam logic [2:0] IDX_LAST = 3'd7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  function automatic work_t h_init();
    work_t h;
    h[0] = 32'h6a09e667;
    h[1] = 32'hbb67ae85;
    h[2] = 32'h3c6ef372;
    h[3] = 32'ha54ff53a;
    h[4] = 32'h510e527f;
    h[5] = 32'h9b05688c;
    h[6] = 32'h1f83d9ab;
    h[7] = 32'h5be0cd19;
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/s256_if.sv
// Valid/ready channel interfaces for the hasher's input bytes and digest words.
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> hdl/s256_round.sv
// SHA-256 round unit: one compression round and one message schedule word per cycle.
module s256_round import s256_pkg::*; (
  input  work_t        cur_i,
  input  logic [511:0] win_i,
  input  logic [5:0]   rnd_i,
  output work_t        nxt_o,
  output logic [31:0]  wnew_o
);

  logic [31:0] w0, w1, w9, w14;
  logic [31:0] sg0, sg1, big0, big1, ch, maj, t1, t2;

  assign w0  = win_i[511:480];
  assign w1  = win_i[479:448];
  assign w9  = win_i[223:192];
  assign w14 = win_i[63:32];

  assign sg0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign sg1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew_o = w0 + sg0 + w9 + sg1;

  assign big1 = rotr(cur_i[4], 6) ^ rotr(cur_i[4], 11) ^ rotr(cur_i[4], 25);
  assign ch   = (cur_i[4] & cur_i[5]) ^ (~cur_i[4] & cur_i[6]);
  assign big0 = rotr(cur_i[0], 2) ^ rotr(cur_i[0], 13) ^ rotr(cur_i[0], 22);
  assign maj  = (cur_i[0] & cur_i[1]) ^ (cur_i[0] & cur_i[2]) ^ (cur_i[1] & cur_i[2]);
  assign t1   = cur_i[7] + big1 + ch + round_k(rnd_i) + w0;
  assign t2   = big0 + maj;

  always_comb begin
    nxt_o[7] = cur_i[6];
    nxt_o[6] = cur_i[5];
    nxt_o[5] = cur_i[4];
    nxt_o[4] = cur_i[3] + t1;
    nxt_o[3] = cur_i[2];
    nxt_o[2] = cur_i[1];
    nxt_o[1] = cur_i[0];
    nxt_o[0] = t1 + t2;
  end

endmodule

>>> hdl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, block window and digest output.
//
// Input channel in_i carries one item per byte: action 0 absorbs data_byte,
// action 1 absorbs it and finishes, action 2 finishes without a byte, action 3
// is dropped. Output channel out_o returns the eight digest words of a finish,
// word_index 0 first, last_word set on word 7.
// An absorb of the 64th byte of a block runs the 64 rounds and then folds the
// result into the chaining words; no byte is taken until that is done. The
// shared round unit, one round per cycle, does every compression.
// A finish shifts in the 0x80 mark and then zero bytes, one per cycle unless a
// compression runs, until 56 bytes are held; if the mark lands past byte 55 the
// block is zero-filled and compressed first. Then the eight length bytes go in,
// one per cycle, the last block is compressed (one or two blocks per finish),
// and the eight words go out, one per cycle while out_o.ready is high.
// in_i.ready is high only while the block is idle. A stalled receiver holds the
// current word in place; nothing is lost. After the last word is taken the
// block is back in its initial state. Reset loads the initial chaining words,
// clears counts and control at once; no clearing pass is needed.
module sha256_byte_stream_hasher import s256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  s256_in_if.sink     in_i,
  s256_out_if.source  out_o
);

  st_e          st_q, st_d, ret_q, ret_d;
  work_t        h_q, h_d;
  work_t        work_q, work_d;
  work_t        rnd_nxt;
  logic [511:0] win_q, win_d;
  logic [63:0]  bits_q, bits_d;
  logic [5:0]   fill_q, fill_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   len_q, len_d;
  logic [2:0]   idx_q, idx_d;
  logic         mark_q, mark_d;
  logic [31:0]  wnew;
  logic         shift_en, go_rnd;
  logic [7:0]   shift_byte;

  s256_round u_round (
    .cur_i  (work_q),
    .win_i  (win_q),
    .rnd_i  (rnd_q),
    .nxt_o  (rnd_nxt),
    .wnew_o (wnew)
  );

  assign in_i.ready        = (st_q == ST_IDLE);
  assign out_o.valid       = (st_q == ST_OUT);
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == IDX_LAST);

  always_comb begin
    st_d       = st_q;
    ret_d      = ret_q;
    h_d        = h_q;
    work_d     = work_q;
    win_d      = win_q;
    bits_d     = bits_q;
    fill_d     = fill_q;
    rnd_d      = rnd_q;
    len_d      = len_q;
    idx_d      = idx_q;
    mark_d     = mark_q;
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    go_rnd     = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.action)
            ACT_ABSORB, ACT_ABS_FIN: begin
              shift_en   = 1'b1;
              shift_byte = in_i.data_byte;
              bits_d     = bits_q + BITS_PER_BYTE;
              if (in_i.action == ACT_ABS_FIN) begin
                mark_d = 1'b1;
                st_d   = ST_PAD;
              end
              if (fill_q == FILL_MAX) begin
                go_rnd = 1'b1;
                ret_d  = (in_i.action == ACT_ABS_FIN) ? ST_PAD : ST_IDLE;
              end
            end
            ACT_FIN: begin
              mark_d = 1'b1;
              st_d   = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (mark_q) begin
          shift_en   = 1'b1;
          shift_byte = PAD_MARK;
          mark_d     = 1'b0;
        end else if (fill_q == LEN_POS) begin
          st_d  = ST_LEN;
          len_d = '0;
        end else begin
          shift_en = 1'b1;
        end
        if (shift_en && fill_q == FILL_MAX) begin
          go_rnd = 1'b1;
          ret_d  = ST_PAD;
        end
      end
      ST_LEN: begin
        shift_en   = 1'b1;
        shift_byte = bits_q[{~len_q, 3'b000} +: 8];
        len_d      = len_q + 3'd1;
        if (len_q == LEN_LAST) begin
          go_rnd = 1'b1;
          ret_d  = ST_OUT;
          idx_d  = '0;
        end
      end
      ST_RND: begin
        work_d = rnd_nxt;
        win_d  = {win_q[479:0], wnew};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == RND_LAST) begin
          st_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + work_q[i];
        end
        st_d = ret_q;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == IDX_LAST) begin
            h_d    = h_init();
            bits_d = '0;
            fill_d = '0;
            st_d   = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (shift_en) begin
      win_d  = {win_q[503:0], shift_byte};
      fill_d = fill_q + 6'd1;
    end
    if (go_rnd) begin
      st_d   = ST_RND;
      work_d = h_q;
      rnd_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ret_q  <= ST_IDLE;
      h_q    <= h_init();
      bits_q <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
      len_q  <= '0;
      idx_q  <= '0;
      mark_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      h_q    <= h_d;
      bits_q <= bits_d;
      fill_q <= fill_d;
      rnd_q  <= rnd_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
  end

endmodule

>>> hdl/s256_checker.sv
// Port-level assertion checker for the SHA-256 byte stream hasher, with its bind.
module s256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // stalled digest word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest item changed while stalled");

  // no byte is taken while a digest is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // words leave in order without gaps
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest word sequence broken");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("block not idle after last digest word");

endmodule

bind sha256_byte_stream_hasher s256_checker u_s256_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .digest_word (out_o.digest_word),
  .word_index  (out_o.word_index),
  .last_word   (out_o.last_word)
);
